// File: rtl/core/assert_macros.svh
// assertion macros for the solver rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds in a cycle, consequent holds in the same cycle
`define QRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qrs assertion failed");

// antecedent holds in a cycle, consequent holds in the next cycle
`define QRS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qrs assertion failed");

`endif

// File: rtl/core/qrs_pkg.sv
// widths, lane types and helper functions of the root solver
package qrs_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int CNT_W      = 3;
    localparam int MAX_ROOTS  = 4;

    // discriminant, signed
    localparam int DW      = 2 * DATA_WIDTH + 2;
    // square root of the discriminant, radicand widened by two times the fraction bits
    localparam int SQ_OUT  = DATA_WIDTH + FRAC_BITS + 1;
    localparam int SQ_IN   = 2 * SQ_OUT;
    localparam int RM_W    = SQ_OUT + 1;
    localparam int RM_X    = RM_W + 2;
    // numerator -b*2^F +/- sqrt, signed
    localparam int NW      = DATA_WIDTH + FRAC_BITS + 3;
    // rounded divide: (2|n|+|d|) / (2|d|)
    localparam int NUMW    = DATA_WIDTH + FRAC_BITS + 4;
    localparam int DVW     = DATA_WIDTH + 2;
    // square root of a quotient for biquadratic roots
    localparam int S2_OUT  = (NUMW + FRAC_BITS + 1) / 2;
    localparam int S2_IN   = 2 * S2_OUT;
    localparam int PIPE_LEN = 3 + SQ_OUT + NUMW + S2_OUT;

    typedef struct packed {
        logic [SQ_IN-1:0]  rad;
        logic [RM_W-1:0]   rem;
        logic [SQ_OUT-1:0] root;
    } sqrt_lane_t;

    typedef struct packed {
        logic [NUMW-1:0] num;
        logic [DVW-1:0]  rem;
        logic [NUMW-1:0] quo;
        logic [DVW-1:0]  dvs;
    } div_lane_t;

    // returns {overflow, value} for a magnitude and a sign
    function automatic logic [DATA_WIDTH:0] sat_root(input logic [NUMW-1:0] mag,
                                                     input logic neg);
        logic [NUMW-1:0] lim;
        logic [DATA_WIDTH:0] res;
        lim = NUMW'(1) << (DATA_WIDTH - 1);
        if (neg)
        begin
            if (mag > lim)
                res = {1'b1, DATA_WIDTH'(lim)};
            else
                res = {1'b0, DATA_WIDTH'(NUMW'(0) - mag)};
        end
        else if (mag > lim - NUMW'(1))
            res = {1'b1, DATA_WIDTH'(lim - NUMW'(1))};
        else
            res = {1'b0, DATA_WIDTH'(mag)};
        return res;
    endfunction

endpackage

// File: rtl/core/qrs_coef_if.sv
// coefficient item channel
interface qrs_coef_if;
    logic valid;
    logic ready;
    logic signed [qrs_pkg::DATA_WIDTH-1:0] a_coef;
    logic signed [qrs_pkg::DATA_WIDTH-1:0] b_coef;
    logic signed [qrs_pkg::DATA_WIDTH-1:0] c_coef;
    modport source (output valid, output a_coef, output b_coef, output c_coef, input ready);
    modport sink (input valid, input a_coef, input b_coef, input c_coef, output ready);
endinterface

// File: rtl/core/qrs_root_if.sv
// root result item channel
interface qrs_root_if;
    logic valid;
    logic ready;
    logic [qrs_pkg::CNT_W-1:0]             root_count;
    logic signed [qrs_pkg::DATA_WIDTH-1:0] root_first;
    logic signed [qrs_pkg::DATA_WIDTH-1:0] root_second;
    logic signed [qrs_pkg::DATA_WIDTH-1:0] root_third;
    logic signed [qrs_pkg::DATA_WIDTH-1:0] root_fourth;
    logic                                  lead_zero;
    logic                                  overflow_flag;
    modport source (output valid, output root_count, output root_first, output root_second,
                    output root_third, output root_fourth, output lead_zero,
                    output overflow_flag, input ready);
    modport sink (input valid, input root_count, input root_first, input root_second,
                  input root_third, input root_fourth, input lead_zero,
                  input overflow_flag, output ready);
endinterface

// File: rtl/core/quadratic_biquadratic_root_solver.sv
// top level of the quadratic and biquadratic real root solver
//
// channel   dir  handshake      payload
// coef      in   valid/ready    a_coef, b_coef, c_coef
// roots     out  valid/ready    root_count, root_first..root_fourth, lead_zero, overflow_flag
// cfg       in   cfg_we         cfg_data -> equation_mode
//
// one item per cycle while the output register is empty or taken; items pass through
// the discriminant root chain, the divide chain and the root-of-quotient chain
// every stage holds while the output register keeps an item that is not taken
// reset clears the valid bits, the output valid and equation_mode
`include "assert_macros.svh"

module quadratic_biquadratic_root_solver (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic            cfg_data,
    qrs_coef_if.sink        coef,
    qrs_root_if.source      roots
);

    localparam int W = qrs_pkg::DATA_WIDTH;
    localparam int F = qrs_pkg::FRAC_BITS;

    typedef struct packed {
        logic                lead;
        logic                mode;
        logic                dneg;
        logic                dzero;
        logic signed [W-1:0] a;
        logic signed [W-1:0] b;
    } side1_t;

    typedef struct packed {
        logic lead;
        logic mode;
        logic dneg;
        logic dzero;
        logic sd1;
        logic nz1;
        logic sd2;
        logic nz2;
    } side2_t;

    typedef struct packed {
        side2_t                     flags;
        logic [qrs_pkg::NUMW-1:0]   mag1;
        logic [qrs_pkg::NUMW-1:0]   mag2;
    } side3_t;

    logic mode_reg;
    logic adv;
    logic [qrs_pkg::PIPE_LEN-1:0] vld_reg;

    // stage 1: products
    logic [W-1:0]   a_abs, b_abs, c_abs;
    logic [2*W-1:0] bb_next, ac_next;
    logic [2*W-1:0] s1_bb_reg, s1_ac_reg;
    logic           s1_sgn_reg, s1_lead_reg, s1_mode_reg;
    logic signed [W-1:0] s1_a_reg, s1_b_reg;

    // stage 2: discriminant
    logic signed [qrs_pkg::DW-1:0] disc;
    logic [qrs_pkg::DW-1:0]        ac4;
    side1_t                        s2_side_next, s2_side_reg;
    logic [qrs_pkg::DW-2:0]        s2_dmag_reg;

    qrs_pkg::sqrt_lane_t sq_w [qrs_pkg::SQ_OUT+1];
    side1_t              side1_reg [qrs_pkg::SQ_OUT];

    // stage 3: numerators and divisor
    side1_t                    s1_last;
    logic signed [qrs_pkg::NW-1:0] bx, sx, base, n1, n2;
    logic signed [W:0]         dx;
    logic [W:0]                d_abs;
    logic [qrs_pkg::NW-1:0]    n1_abs, n2_abs;
    qrs_pkg::div_lane_t        s3_l1_next, s3_l2_next, s3_l1_reg, s3_l2_reg;
    side2_t                    s3_side_next, s3_side_reg;

    qrs_pkg::div_lane_t dv1_w [qrs_pkg::NUMW+1];
    qrs_pkg::div_lane_t dv2_w [qrs_pkg::NUMW+1];
    side2_t             side2_reg [qrs_pkg::NUMW];

    qrs_pkg::sqrt_lane_t r1_w [qrs_pkg::S2_OUT+1];
    qrs_pkg::sqrt_lane_t r2_w [qrs_pkg::S2_OUT+1];
    side3_t              side3_next;
    side3_t              side3_reg [qrs_pkg::S2_OUT];

    // output
    side3_t                   fin;
    logic [qrs_pkg::NUMW-1:0] rt1, rt2;
    logic                     neg1, neg2, p1, p2, use2;
    logic [W:0]               sat1, sat2, pr1, nr1, pr2, nr2;
    logic [W-1:0]             slot_next [qrs_pkg::MAX_ROOTS];
    logic [qrs_pkg::CNT_W-1:0] cnt_next;
    logic                     lead_next, ovf_next;

    logic                     out_vld_reg;
    logic [W-1:0]             slot_reg [qrs_pkg::MAX_ROOTS];
    logic [qrs_pkg::CNT_W-1:0] cnt_reg;
    logic                     lead_reg, ovf_reg;

    assign adv        = !out_vld_reg || roots.ready;
    assign coef.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b0;
        else if (cfg_we)
            mode_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg     <= {vld_reg[qrs_pkg::PIPE_LEN-2:0], coef.valid};
            out_vld_reg <= vld_reg[qrs_pkg::PIPE_LEN-1];
        end
    end

    // stage 1
    always_comb
    begin
        a_abs   = coef.a_coef[W-1] ? W'(-coef.a_coef) : W'(coef.a_coef);
        b_abs   = coef.b_coef[W-1] ? W'(-coef.b_coef) : W'(coef.b_coef);
        c_abs   = coef.c_coef[W-1] ? W'(-coef.c_coef) : W'(coef.c_coef);
        bb_next = (2*W)'(b_abs) * (2*W)'(b_abs);
        ac_next = (2*W)'(a_abs) * (2*W)'(c_abs);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_bb_reg   <= bb_next;
            s1_ac_reg   <= ac_next;
            s1_sgn_reg  <= coef.a_coef[W-1] ^ coef.c_coef[W-1];
            s1_lead_reg <= (coef.a_coef == '0);
            s1_mode_reg <= mode_reg;
            s1_a_reg    <= coef.a_coef;
            s1_b_reg    <= coef.b_coef;
        end
    end

    // stage 2
    always_comb
    begin
        ac4  = {s1_ac_reg, 2'b00};
        if (s1_sgn_reg)
            disc = signed'(qrs_pkg::DW'(s1_bb_reg)) + signed'(ac4);
        else
            disc = signed'(qrs_pkg::DW'(s1_bb_reg)) - signed'(ac4);
        s2_side_next.lead  = s1_lead_reg;
        s2_side_next.mode  = s1_mode_reg;
        s2_side_next.dneg  = disc[qrs_pkg::DW-1];
        s2_side_next.dzero = (disc == '0);
        s2_side_next.a     = s1_a_reg;
        s2_side_next.b     = s1_b_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_side_reg <= s2_side_next;
            s2_dmag_reg <= disc[qrs_pkg::DW-2:0];
        end
    end

    // discriminant root chain
    always_comb
    begin
        sq_w[0].rad  = qrs_pkg::SQ_IN'({s2_dmag_reg, {(2*F){1'b0}}});
        sq_w[0].rem  = '0;
        sq_w[0].root = '0;
    end

    for (genvar i = 0; i < qrs_pkg::SQ_OUT; i++)
    begin : g_sq
        qrs_sqrt_cell u_cell (
            .clk      (clk),
            .en       (adv),
            .lane_in  (sq_w[i]),
            .lane_out (sq_w[i+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side1_reg[0] <= s2_side_reg;
            for (int i = 1; i < qrs_pkg::SQ_OUT; i++)
                side1_reg[i] <= side1_reg[i-1];
        end
    end

    // stage 3
    always_comb
    begin
        s1_last = side1_reg[qrs_pkg::SQ_OUT-1];
        bx      = qrs_pkg::NW'(s1_last.b);
        sx      = signed'(qrs_pkg::NW'(sq_w[qrs_pkg::SQ_OUT].root));
        base    = -(bx <<< F);
        n1      = base + sx;
        n2      = base - sx;
        dx      = (W+1)'(s1_last.a) <<< 1;
        d_abs   = dx[W] ? (W+1)'(-dx) : (W+1)'(dx);
        n1_abs  = n1[qrs_pkg::NW-1] ? qrs_pkg::NW'(-n1) : qrs_pkg::NW'(n1);
        n2_abs  = n2[qrs_pkg::NW-1] ? qrs_pkg::NW'(-n2) : qrs_pkg::NW'(n2);

        s3_l1_next.num = (qrs_pkg::NUMW'(n1_abs) << 1) + qrs_pkg::NUMW'(d_abs);
        s3_l1_next.rem = '0;
        s3_l1_next.quo = '0;
        s3_l1_next.dvs = qrs_pkg::DVW'(d_abs) << 1;
        s3_l2_next.num = (qrs_pkg::NUMW'(n2_abs) << 1) + qrs_pkg::NUMW'(d_abs);
        s3_l2_next.rem = '0;
        s3_l2_next.quo = '0;
        s3_l2_next.dvs = qrs_pkg::DVW'(d_abs) << 1;

        s3_side_next.lead  = s1_last.lead;
        s3_side_next.mode  = s1_last.mode;
        s3_side_next.dneg  = s1_last.dneg;
        s3_side_next.dzero = s1_last.dzero;
        s3_side_next.sd1   = n1[qrs_pkg::NW-1] != s1_last.a[W-1];
        s3_side_next.nz1   = (n1 == '0);
        s3_side_next.sd2   = n2[qrs_pkg::NW-1] != s1_last.a[W-1];
        s3_side_next.nz2   = (n2 == '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_l1_reg   <= s3_l1_next;
            s3_l2_reg   <= s3_l2_next;
            s3_side_reg <= s3_side_next;
        end
    end

    // divide chains, one per quotient
    assign dv1_w[0] = s3_l1_reg;
    assign dv2_w[0] = s3_l2_reg;

    for (genvar i = 0; i < qrs_pkg::NUMW; i++)
    begin : g_dv
        qrs_div_cell u_div1 (
            .clk      (clk),
            .en       (adv),
            .lane_in  (dv1_w[i]),
            .lane_out (dv1_w[i+1])
        );
        qrs_div_cell u_div2 (
            .clk      (clk),
            .en       (adv),
            .lane_in  (dv2_w[i]),
            .lane_out (dv2_w[i+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side2_reg[0] <= s3_side_reg;
            for (int i = 1; i < qrs_pkg::NUMW; i++)
                side2_reg[i] <= side2_reg[i-1];
        end
    end

    // root-of-quotient chains; radicand sits at the top so fewer cells suffice
    always_comb
    begin
        side3_next.flags = side2_reg[qrs_pkg::NUMW-1];
        side3_next.mag1  = dv1_w[qrs_pkg::NUMW].quo;
        side3_next.mag2  = dv2_w[qrs_pkg::NUMW].quo;
        r1_w[0].rad  = qrs_pkg::SQ_IN'(qrs_pkg::S2_IN'({side3_next.mag1, {F{1'b0}}}))
                       << (qrs_pkg::SQ_IN - qrs_pkg::S2_IN);
        r1_w[0].rem  = '0;
        r1_w[0].root = '0;
        r2_w[0].rad  = qrs_pkg::SQ_IN'(qrs_pkg::S2_IN'({side3_next.mag2, {F{1'b0}}}))
                       << (qrs_pkg::SQ_IN - qrs_pkg::S2_IN);
        r2_w[0].rem  = '0;
        r2_w[0].root = '0;
    end

    for (genvar i = 0; i < qrs_pkg::S2_OUT; i++)
    begin : g_rt
        qrs_sqrt_cell u_rt1 (
            .clk      (clk),
            .en       (adv),
            .lane_in  (r1_w[i]),
            .lane_out (r1_w[i+1])
        );
        qrs_sqrt_cell u_rt2 (
            .clk      (clk),
            .en       (adv),
            .lane_in  (r2_w[i]),
            .lane_out (r2_w[i+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side3_reg[0] <= side3_next;
            for (int i = 1; i < qrs_pkg::S2_OUT; i++)
                side3_reg[i] <= side3_reg[i-1];
        end
    end

    // root selection and saturation
    always_comb
    begin
        fin  = side3_reg[qrs_pkg::S2_OUT-1];
        rt1  = qrs_pkg::NUMW'(r1_w[qrs_pkg::S2_OUT].root[qrs_pkg::S2_OUT-1:0]);
        rt2  = qrs_pkg::NUMW'(r2_w[qrs_pkg::S2_OUT].root[qrs_pkg::S2_OUT-1:0]);
        neg1 = fin.flags.sd1 && (fin.mag1 != '0);
        neg2 = fin.flags.sd2 && (fin.mag2 != '0);
        p1   = fin.flags.nz1 || !fin.flags.sd1;
        p2   = fin.flags.nz2 || !fin.flags.sd2;
        use2 = p2 && !fin.flags.dzero;
        sat1 = qrs_pkg::sat_root(fin.mag1, neg1);
        sat2 = qrs_pkg::sat_root(fin.mag2, neg2);
        pr1  = qrs_pkg::sat_root(rt1, 1'b0);
        nr1  = qrs_pkg::sat_root(rt1, 1'b1);
        pr2  = qrs_pkg::sat_root(rt2, 1'b0);
        nr2  = qrs_pkg::sat_root(rt2, 1'b1);

        for (int i = 0; i < qrs_pkg::MAX_ROOTS; i++)
            slot_next[i] = '0;
        cnt_next  = '0;
        ovf_next  = 1'b0;
        lead_next = fin.flags.lead;

        if (!fin.flags.lead && !fin.flags.dneg)
        begin
            if (!fin.flags.mode)
            begin
                slot_next[0] = sat1[W-1:0];
                if (fin.flags.dzero)
                begin
                    cnt_next = qrs_pkg::CNT_W'(1);
                    ovf_next = sat1[W];
                end
                else
                begin
                    slot_next[1] = sat2[W-1:0];
                    cnt_next     = qrs_pkg::CNT_W'(2);
                    ovf_next     = sat1[W] | sat2[W];
                end
            end
            else if (p1)
            begin
                slot_next[0] = pr1[W-1:0];
                slot_next[1] = nr1[W-1:0];
                if (use2)
                begin
                    slot_next[2] = pr2[W-1:0];
                    slot_next[3] = nr2[W-1:0];
                    cnt_next     = qrs_pkg::CNT_W'(4);
                    ovf_next     = pr1[W] | nr1[W] | pr2[W] | nr2[W];
                end
                else
                begin
                    cnt_next = qrs_pkg::CNT_W'(2);
                    ovf_next = pr1[W] | nr1[W];
                end
            end
            else if (use2)
            begin
                slot_next[0] = pr2[W-1:0];
                slot_next[1] = nr2[W-1:0];
                cnt_next     = qrs_pkg::CNT_W'(2);
                ovf_next     = pr2[W] | nr2[W];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            slot_reg <= slot_next;
            cnt_reg  <= cnt_next;
            lead_reg <= lead_next;
            ovf_reg  <= ovf_next;
        end
    end

    assign roots.valid         = out_vld_reg;
    assign roots.root_count    = cnt_reg;
    assign roots.root_first    = signed'(slot_reg[0]);
    assign roots.root_second   = signed'(slot_reg[1]);
    assign roots.root_third    = signed'(slot_reg[2]);
    assign roots.root_fourth   = signed'(slot_reg[3]);
    assign roots.lead_zero     = lead_reg;
    assign roots.overflow_flag = ovf_reg;

    `QRS_ASSERT_IMP(a_lead_clear, clk, rst_n, out_vld_reg && lead_reg, cnt_reg == '0 && !ovf_reg)
    `QRS_ASSERT_IMP(a_count_range, clk, rst_n, out_vld_reg, cnt_reg <= qrs_pkg::CNT_W'(qrs_pkg::MAX_ROOTS))
    `QRS_ASSERT_IMP(a_none_zero, clk, rst_n, out_vld_reg && cnt_reg == '0, slot_reg[0] == '0 && slot_reg[1] == '0 && !ovf_reg)
    `QRS_ASSERT_NXT(a_hold_pipe, clk, rst_n, !adv, $stable(vld_reg) && $stable(out_vld_reg))

endmodule

// File: rtl/core/qrs_sqrt_cell.sv
// one radix-2 step of a restoring square root, registered
module qrs_sqrt_cell (
    input  logic                clk,
    input  logic                en,
    input  qrs_pkg::sqrt_lane_t lane_in,
    output qrs_pkg::sqrt_lane_t lane_out
);

    qrs_pkg::sqrt_lane_t lane_reg;
    qrs_pkg::sqrt_lane_t lane_next;
    logic [qrs_pkg::RM_X-1:0] part;
    logic [qrs_pkg::RM_X-1:0] trial;
    logic take;

    always_comb
    begin
        part  = {lane_in.rem, lane_in.rad[qrs_pkg::SQ_IN-1 -: 2]};
        trial = qrs_pkg::RM_X'({lane_in.root, 2'b01});
        take  = (part >= trial);
        lane_next.rad  = lane_in.rad << 2;
        lane_next.rem  = take ? qrs_pkg::RM_W'(part - trial) : qrs_pkg::RM_W'(part);
        lane_next.root = {lane_in.root[qrs_pkg::SQ_OUT-2:0], take};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            lane_reg <= lane_next;
    end

    assign lane_out = lane_reg;

endmodule

// File: rtl/core/qrs_div_cell.sv
// one step of a restoring divide, registered
module qrs_div_cell (
    input  logic               clk,
    input  logic               en,
    input  qrs_pkg::div_lane_t lane_in,
    output qrs_pkg::div_lane_t lane_out
);

    qrs_pkg::div_lane_t lane_reg;
    qrs_pkg::div_lane_t lane_next;
    logic [qrs_pkg::DVW:0] part;
    logic [qrs_pkg::DVW:0] dvs_x;
    logic take;

    always_comb
    begin
        part  = {lane_in.rem, lane_in.num[qrs_pkg::NUMW-1]};
        dvs_x = {1'b0, lane_in.dvs};
        take  = (part >= dvs_x);
        lane_next.num = lane_in.num << 1;
        lane_next.rem = take ? qrs_pkg::DVW'(part - dvs_x) : qrs_pkg::DVW'(part);
        lane_next.quo = {lane_in.quo[qrs_pkg::NUMW-2:0], take};
        lane_next.dvs = lane_in.dvs;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            lane_reg <= lane_next;
    end

    assign lane_out = lane_reg;

endmodule
